// ===== hdl/mrc_pkg.sv =====
// Shared types and constants for the mixed-radix index converter.
package mrc_pkg;

  // Field widths
  localparam int DIMS       = 4;
  localparam int DIM_W      = 2;
  localparam int COORD_W    = 16;
  localparam int FLAT_W     = 32;
  localparam int COUNT_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int TDATA_W    = 96;

  // Serial step counts and counter widths
  localparam int MUL_STEPS = COORD_W;
  localparam int DIV_STEPS = FLAT_W;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS + 1);
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_FIRST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_LAST  = 3'd4;

  // Commands
  localparam logic CMD_FLATTEN = 1'b0;
  localparam logic CMD_SPLIT   = 1'b1;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_STRIDE = 5'b00010,
    ST_FLAT   = 5'b00100,
    ST_SPLIT  = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  // Control into the serial multiply-accumulate unit
  typedef struct packed {
    logic start;
    logic keep_acc;
  } mac_cmd_t;

endpackage

// ===== hdl/mixed_radix_index_convert.sv =====
// Top level: converts coordinates to a row-major offset and back.
//
// Input stream: tuser carries the command (flatten or split), tdata the four
// coordinates and the flat offset. Output stream: tdata carries the flat
// result and four coordinates; the fields that the command does not produce
// are zero. Configuration: cfg_index 0 sets the dimension count, 1 to 4 set
// the sizes of dimensions 0 to 3; writes are taken only while idle.
// One item is processed at a time. Flatten runs one serial shift-add per
// dimension in use; split runs one serial restoring division per dimension
// in use, from the highest dimension down to dimension 0.
// After a size write the strides are rebuilt by three serial multiplies,
// with both input ports held off meanwhile.
// The output register lets the next request be taken while a result waits;
// a stalled receiver holds that result, and the following one waits in the
// sequencer until the register frees. Reset sets all sizes and strides to one,
// the dimension count to one, and empties the output.
module mixed_radix_index_convert (
  input  logic                               clk,
  input  logic                               rst,
  // Input requests
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // coord_in0, coord_in1, coord_in2, coord_in3, flat_index_in
  input  logic [mrc_pkg::TDATA_W-1:0]        s_axis_tdata,
  // cmd
  input  logic                               s_axis_tuser,
  // Results
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // flat_result, coord_out0, coord_out1, coord_out2, coord_out3
  output logic [mrc_pkg::TDATA_W-1:0]        m_axis_tdata,
  // Configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mrc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mrc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  mrc_pkg::state_t state;
  logic                                run;
  logic [mrc_pkg::DIM_W-1:0]           dim;
  logic [mrc_pkg::DIM_W-1:0]           dim_prev;
  logic [mrc_pkg::DIM_W-1:0]           top_dim;
  logic [mrc_pkg::COUNT_W-1:0]         dim_count;
  logic [mrc_pkg::COORD_W-1:0]         size_reg   [mrc_pkg::DIMS];
  logic [mrc_pkg::FLAT_W-1:0]          stride     [mrc_pkg::DIMS];
  logic [mrc_pkg::COORD_W-1:0]         coords     [mrc_pkg::DIMS];
  logic [mrc_pkg::COORD_W-1:0]         res_coord  [mrc_pkg::DIMS];
  logic [mrc_pkg::FLAT_W-1:0]          res_flat;
  logic [mrc_pkg::FLAT_W-1:0]          rem;
  logic [mrc_pkg::TDATA_W-1:0]         out_data;
  logic                                out_valid;
  logic [mrc_pkg::CFG_IDX_W-1:0]       size_sel;
  logic                                in_take;
  logic                                cfg_take;
  logic                                out_load;

  mrc_pkg::mac_cmd_t                   mac_cmd;
  logic [mrc_pkg::FLAT_W-1:0]          mac_mcand;
  logic [mrc_pkg::COORD_W-1:0]         mac_mplier;
  logic [mrc_pkg::FLAT_W-1:0]          mac_acc;
  logic                                mac_done;
  logic                                div_start;
  logic [mrc_pkg::COORD_W-1:0]         div_quot;
  logic [mrc_pkg::FLAT_W-1:0]          div_rem;
  logic                                div_done;

  // Handshakes
  assign cfg_ready     = (state == mrc_pkg::ST_IDLE);
  assign s_axis_tready = (state == mrc_pkg::ST_IDLE) && !cfg_valid;
  assign cfg_take      = cfg_valid && cfg_ready;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state == mrc_pkg::ST_DONE) && (!out_valid || m_axis_tready);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign size_sel      = cfg_index - mrc_pkg::REG_SIZE_FIRST;
  assign dim_prev      = dim - 1'b1;

  // Highest dimension in use, count clamped to 1..DIMS
  always_comb begin
    if (dim_count == '0) begin
      top_dim = '0;
    end else if (dim_count > mrc_pkg::COUNT_W'(mrc_pkg::DIMS)) begin
      top_dim = mrc_pkg::DIM_W'(mrc_pkg::DIMS - 1);
    end else begin
      top_dim = mrc_pkg::DIM_W'(dim_count - 1'b1);
    end
  end

  // Operand selection for the serial units
  always_comb begin
    mac_cmd.start    = !run && ((state == mrc_pkg::ST_FLAT) || (state == mrc_pkg::ST_STRIDE));
    mac_cmd.keep_acc = (state == mrc_pkg::ST_FLAT) && (dim != '0);
    if (state == mrc_pkg::ST_STRIDE) begin
      mac_mcand  = stride[dim_prev];
      mac_mplier = size_reg[dim_prev];
    end else begin
      mac_mcand  = stride[dim];
      mac_mplier = coords[dim];
    end
    div_start = !run && (state == mrc_pkg::ST_SPLIT);
  end

  mrc_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .cmd    (mac_cmd),
    .mcand  (mac_mcand),
    .mplier (mac_mplier),
    .acc    (mac_acc),
    .done   (mac_done)
  );

  mrc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (rem),
    .divisor   (stride[dim]),
    .quot_sat  (div_quot),
    .remainder (div_rem),
    .done      (div_done)
  );

  // Sequencer, configuration registers and stride table
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mrc_pkg::ST_IDLE;
      run       <= 1'b0;
      dim       <= '0;
      out_valid <= 1'b0;
      dim_count <= mrc_pkg::COUNT_W'(1);
      for (int i = 0; i < mrc_pkg::DIMS; i++) begin
        size_reg[i] <= mrc_pkg::COORD_W'(1);
        stride[i]   <= mrc_pkg::FLAT_W'(1);
      end
    end else begin
      // Result register: loaded by the sequencer, emptied by the receiver
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        mrc_pkg::ST_IDLE: begin
          run <= 1'b0;
          if (cfg_take) begin
            if (cfg_index == mrc_pkg::REG_DIM_COUNT) begin
              dim_count <= cfg_data[mrc_pkg::COUNT_W-1:0];
            end else if (cfg_index inside {[mrc_pkg::REG_SIZE_FIRST:mrc_pkg::REG_SIZE_LAST]})
            begin
              size_reg[size_sel[mrc_pkg::DIM_W-1:0]] <= cfg_data;
              dim   <= mrc_pkg::DIM_W'(1);
              state <= mrc_pkg::ST_STRIDE;
            end
          end else if (in_take) begin
            if (s_axis_tuser == mrc_pkg::CMD_SPLIT) begin
              dim   <= top_dim;
              state <= mrc_pkg::ST_SPLIT;
            end else begin
              dim   <= '0;
              state <= mrc_pkg::ST_FLAT;
            end
          end
        end
        mrc_pkg::ST_STRIDE: begin
          if (!run) begin
            run <= 1'b1;
          end else if (mac_done) begin
            run         <= 1'b0;
            stride[dim] <= mac_acc;
            if (dim == mrc_pkg::DIM_W'(mrc_pkg::DIMS - 1)) begin
              state <= mrc_pkg::ST_IDLE;
            end else begin
              dim <= dim + 1'b1;
            end
          end
        end
        mrc_pkg::ST_FLAT: begin
          if (!run) begin
            run <= 1'b1;
          end else if (mac_done) begin
            run <= 1'b0;
            if (dim == top_dim) begin
              state <= mrc_pkg::ST_DONE;
            end else begin
              dim <= dim + 1'b1;
            end
          end
        end
        mrc_pkg::ST_SPLIT: begin
          if (!run) begin
            run <= 1'b1;
          end else if (div_done) begin
            run <= 1'b0;
            if (dim == '0) begin
              state <= mrc_pkg::ST_DONE;
            end else begin
              dim <= dim_prev;
            end
          end
        end
        mrc_pkg::ST_DONE: begin
          if (out_load) begin
            state <= mrc_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= mrc_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Request capture and result assembly
  always_ff @(posedge clk) begin
    if (in_take) begin
      coords[0] <= s_axis_tdata[15:0];
      coords[1] <= s_axis_tdata[31:16];
      coords[2] <= s_axis_tdata[47:32];
      coords[3] <= s_axis_tdata[63:48];
      rem       <= s_axis_tdata[95:64];
      res_flat  <= '0;
      for (int i = 0; i < mrc_pkg::DIMS; i++) begin
        res_coord[i] <= '0;
      end
    end
    if ((state == mrc_pkg::ST_FLAT) && run && mac_done && (dim == top_dim)) begin
      res_flat <= mac_acc;
    end
    if ((state == mrc_pkg::ST_SPLIT) && run && div_done) begin
      res_coord[dim] <= div_quot;
      rem            <= div_rem;
    end
    if (out_load) begin
      out_data <= {res_coord[3], res_coord[2], res_coord[1], res_coord[0], res_flat};
    end
  end

endmodule

// ===== hdl/mrc_mac.sv =====
// Bit-serial multiply-accumulate: one multiplier bit per cycle.
module mrc_mac (
  input  logic                          clk,
  input  logic                          rst,
  input  mrc_pkg::mac_cmd_t             cmd,
  input  logic [mrc_pkg::FLAT_W-1:0]    mcand,
  input  logic [mrc_pkg::COORD_W-1:0]   mplier,
  output logic [mrc_pkg::FLAT_W-1:0]    acc,
  output logic                          done
);

  logic [mrc_pkg::FLAT_W-1:0]    mc;
  logic [mrc_pkg::COORD_W-1:0]   mp;
  logic [mrc_pkg::MUL_CNT_W-1:0] cnt;

  // Step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        cnt <= mrc_pkg::MUL_CNT_W'(mrc_pkg::MUL_STEPS);
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        done <= (cnt == mrc_pkg::MUL_CNT_W'(1));
      end
    end
  end

  // Shift-add datapath, modulo 2^FLAT_W
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mc <= mcand;
      mp <= mplier;
      if (!cmd.keep_acc) begin
        acc <= '0;
      end
    end else if (cnt != '0) begin
      if (mp[0]) begin
        acc <= acc + mc;
      end
      mc <= {mc[mrc_pkg::FLAT_W-2:0], 1'b0};
      mp <= {1'b0, mp[mrc_pkg::COORD_W-1:1]};
    end
  end

endmodule

// ===== hdl/mrc_div.sv =====
// Restoring divider: one quotient bit per cycle, quotient saturated to a coordinate.
module mrc_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [mrc_pkg::FLAT_W-1:0]    dividend,
  input  logic [mrc_pkg::FLAT_W-1:0]    divisor,
  output logic [mrc_pkg::COORD_W-1:0]   quot_sat,
  output logic [mrc_pkg::FLAT_W-1:0]    remainder,
  output logic                          done
);

  logic [mrc_pkg::FLAT_W-1:0]    dq;
  logic [mrc_pkg::FLAT_W-1:0]    dv;
  logic [mrc_pkg::DIV_CNT_W-1:0] cnt;
  logic [mrc_pkg::FLAT_W:0]      shifted;
  logic [mrc_pkg::FLAT_W:0]      diff;
  logic                          ge;

  // One trial subtract; a zero divisor gives all ones and keeps the dividend
  always_comb begin
    shifted = {remainder, dq[mrc_pkg::FLAT_W-1]};
    diff    = shifted - {1'b0, dv};
    ge      = (shifted >= {1'b0, dv});
  end

  assign quot_sat = (|dq[mrc_pkg::FLAT_W-1:mrc_pkg::COORD_W]) ? '1
                                                              : dq[mrc_pkg::COORD_W-1:0];

  // Step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= mrc_pkg::DIV_CNT_W'(mrc_pkg::DIV_STEPS);
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        done <= (cnt == mrc_pkg::DIV_CNT_W'(1));
      end
    end
  end

  // Dividend shifts out as quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      dq        <= dividend;
      dv        <= divisor;
      remainder <= '0;
    end else if (cnt != '0) begin
      remainder <= ge ? diff[mrc_pkg::FLAT_W-1:0] : shifted[mrc_pkg::FLAT_W-1:0];
      dq        <= {dq[mrc_pkg::FLAT_W-2:0], ge};
    end
  end

endmodule
